// ===== rtl/lsf_pkg.sv =====
// lsf_pkg: shared constants, register indexes and the case-fold function
// of the line substring filter; no dependencies
package lsf_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int CHUNK_MAX_DEF   = 8191;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 32;
    localparam int PAT_W      = PAT_BYTES * BYTE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PLEN_W     = 6;
    localparam int LNUM_W     = 31;
    localparam int LLEN_W     = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_SELECT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_D = 3'd6;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic [LNUM_W-1:0] LINE_NUMBER_MAX = {LNUM_W{1'b1}};

    // map ascii A-Z to a-z when enabled
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic en);
        if (en && (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

// ===== rtl/line_substring_filter_top.sv =====
// line_substring_filter_top: fixed-string line filter over a byte stream
// depends on lsf_pkg (constants, register indexes, fold_byte)

// One text byte is taken per cycle unless the input stalls. A line chunk
// closes after a newline, after CHUNK_MAX bytes, or at the byte flagged final;
// at close the chunk is selected if the configured pattern was seen in it (or
// was not, with invert_select set) and one item with its line number and
// length is produced. A closing byte is accepted into the byte stage, which
// shifts the recent-byte window and updates the fill and line counters, and
// then passes through the window compare into the result register, from
// which its result shows on the output. The input stalls only when a chunk
// closes while the result register still holds an item that is not taken.
// Configuration writes take effect at once and are meant for idle periods.
module line_substring_filter_top #(
    parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF,
    parameter int CHUNK_MAX   = lsf_pkg::CHUNK_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [lsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // text byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lsf_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                          i_final_byte,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lsf_pkg::LNUM_W-1:0]    o_line_number,
    output logic [lsf_pkg::LLEN_W-1:0]    o_line_length
);
    import lsf_pkg::*;

    // window depth: pattern bytes past 31 read as zero, and a zero byte
    // blocks any match, so more than 32 bytes never help
    localparam int WIN   = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
    localparam int WIN_W = WIN * BYTE_W;
    localparam int LW_W  = $clog2(WIN + 1);
    localparam int FW    = $clog2(CHUNK_MAX + 1);
    // lengths above the window never match when PATTERN_MAX exceeds 32, else they clamp to the window
    localparam bit LONG_NEVER = (PATTERN_MAX > WIN);

    // configuration registers
    logic [PLEN_W-1:0] r_pattern_length;
    logic              r_fold_case;
    logic              r_invert_select;
    logic [PAT_W-1:0]  r_pattern;

    // chunk state, updated as a byte is accepted
    logic [WIN_W-1:0]  r_window;
    logic [FW-1:0]     r_fill;
    logic              r_zero_seen;
    logic [LNUM_W-1:0] r_line;

    // byte stage
    logic              r_s1_valid;
    logic [FW-1:0]     r_s1_fill;
    logic              r_s1_zero;
    logic              r_s1_end;
    logic [LNUM_W-1:0] r_s1_line;

    // compare stage state and result register
    logic              r_seen;
    logic              r_out_valid;
    logic [LNUM_W-1:0] r_out_number;
    logic [LLEN_W-1:0] r_out_length;

    logic              in_accept;
    logic              s1_move;
    logic              out_free;

    logic [FW-1:0]     n_fill;
    logic              n_zero;
    logic              n_end;
    logic [LNUM_W-1:0] n_line;

    logic              len_zero;
    logic              len_over;
    logic [LW_W-1:0]   len_eff;
    logic [LW_W-1:0]   shamt;
    logic              fill_ok;
    logic [WIN_W-1:0]  aligned;
    logic              bytes_eq;
    logic              win_match;
    logic              n_seen;

    // handshake: the byte stage only waits on a closing chunk with the
    // result register occupied and not taken
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && (!r_s1_end || out_free);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_accept  = i_in_valid && o_in_ready;

    // next chunk state for the incoming byte
    always_comb begin
        n_fill = r_fill + 1'b1;
        n_zero = r_zero_seen || (i_text_byte == CHAR_NUL);
        n_end  = (i_text_byte == CHAR_NEWLINE) || (n_fill >= FW'(CHUNK_MAX))
                 || i_final_byte;
        n_line = r_line;
        if (n_end && (r_line != LINE_NUMBER_MAX)) begin
            n_line = r_line + 1'b1;
        end
    end

    // window compare: shift the window so the oldest byte in use lands in
    // the top lane, then compare lane k with pattern byte WIN-1-k
    always_comb begin
        len_zero = (r_pattern_length == '0);
        len_over = (32'(r_pattern_length) > WIN);
        len_eff  = len_over ? LW_W'(WIN) : LW_W'(r_pattern_length);
        shamt    = LW_W'(WIN) - len_eff;
        fill_ok  = (32'(r_s1_fill) >= 32'(len_eff));
        aligned  = r_window << {shamt, 3'b000};
        bytes_eq = 1'b1;
        for (int k = 0; k < WIN; k++) begin
            if (LW_W'(k) >= shamt) begin
                if (fold_byte(aligned[k*BYTE_W +: BYTE_W], r_fold_case) !=
                    fold_byte(r_pattern[(WIN-1-k)*BYTE_W +: BYTE_W], r_fold_case)) begin
                    bytes_eq = 1'b0;
                end
            end
        end
        win_match = len_zero || (!(len_over && LONG_NEVER) && fill_ok && bytes_eq);
        n_seen    = r_seen || (!r_s1_zero && win_match);
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= PLEN_W'(1);
            r_fold_case      <= 1'b0;
            r_invert_select  <= 1'b0;
            r_pattern        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[PLEN_W-1:0];
                REG_FOLD_CASE:      r_fold_case      <= i_cfg_data[0];
                REG_INVERT_SELECT:  r_invert_select  <= i_cfg_data[0];
                REG_PATTERN_WORD_A: r_pattern[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PATTERN_WORD_B: r_pattern[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PATTERN_WORD_C: r_pattern[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_PATTERN_WORD_D: r_pattern[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // recent-byte window, newest byte in the low lane
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_window <= WIN_W'({r_window, i_text_byte});
        end
    end

    // byte stage and chunk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fill      <= '0;
            r_zero_seen <= 1'b0;
            r_line      <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid  <= 1'b1;
                r_fill      <= n_end ? '0 : n_fill;
                r_zero_seen <= n_end ? 1'b0 : n_zero;
                // end of file restarts numbering at line 1
                r_line      <= i_final_byte ? '0 : n_line;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_fill <= n_fill;
            r_s1_zero <= n_zero;
            r_s1_end  <= n_end;
            r_s1_line <= n_line;
        end
    end

    // compare stage: accumulate the match flag, decide at chunk close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_move && r_s1_end && (n_seen != r_invert_select)) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_move) begin
                r_seen <= r_s1_end ? 1'b0 : n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_end && (n_seen != r_invert_select)) begin
            r_out_number <= r_s1_line;
            r_out_length <= LLEN_W'(r_s1_fill);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_out_number;
    assign o_line_length = r_out_length;

endmodule

// ===== rtl/lsf_checker.sv =====
// lsf_checker: port-level assertions for line_substring_filter_top
// depends on lsf_pkg; bound to the top level at the end of this file
module lsf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [lsf_pkg::LNUM_W-1:0] o_line_number,
    input logic [lsf_pkg::LLEN_W-1:0] o_line_length
);
    import lsf_pkg::*;

    // a waiting result item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_line_number) && $stable(o_line_length)))
        else $error("result item changed before it was taken");

    // line numbers are one-based
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_number != '0))
        else $error("result item with line number zero");

    // with the result register empty the input never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // a new result goes back to an accepted byte through the byte stage and the result register
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result item without a byte two cycles earlier");

endmodule

bind line_substring_filter_top lsf_checker u_lsf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_line_number (o_line_number),
    .o_line_length (o_line_length)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for the line substring filter, byte items in, line items out
// depends on lsf_pkg and line_substring_filter_top; drives both channels with random idling

module tb_top;
    import lsf_pkg::*;

    localparam int PAT_LIMIT    = PATTERN_MAX_DEF;
    localparam int CHUNK_LIMIT  = CHUNK_MAX_DEF;
    localparam int PLEN_TOP     = (1 << PLEN_W) - 1;
    localparam int CYCLE_LIMIT  = 400000;
    // spare cycles after the last result, before the next filter setting
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 8;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BYTES   = 55;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [BYTE_W-1:0]    CHAR_FILL    = 8'h78;
    localparam logic [BYTE_W-1:0]    CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0]    CHAR_LOWER_Z = 8'h7A;
    localparam logic [PAT_W-1:0]     PAT_AB       = PAT_W'(16'h6261);
    localparam logic [PAT_W-1:0]     PAT_ABCD     = PAT_W'(32'h64636261);

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              ends_file;
    } text_item_t;

    typedef struct packed {
        logic [LNUM_W-1:0] number;
        logic [LLEN_W-1:0] len;
    } line_hit_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_BURSTY
    } ready_mode_t;

    // dut ports, all inputs known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [BYTE_W-1:0]     i_text_byte = '0;
    logic                  i_final_byte = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [LNUM_W-1:0]     o_line_number;
    logic [LLEN_W-1:0]     o_line_length;

    line_substring_filter_top DUT (.*);

    // byte items waiting for the driver, line items waiting for the dut
    text_item_t  pending_bytes[$];
    line_hit_t   expected_hits[$];
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;

    // shadow copy of the filter registers
    logic [PLEN_W-1:0] cfg_pat_len;
    logic              cfg_fold;
    logic              cfg_invert;
    logic [PAT_W-1:0]  cfg_pattern;

    // shadow copy of the line scan state
    logic [BYTE_W-1:0] window_q[PAT_LIMIT];
    int unsigned       fill_count;
    logic              hit_in_chunk;
    logic              nul_in_chunk;
    logic [LNUM_W-1:0] line_count;

    // driver and monitor pacing
    int          burst_left = 1;
    int          gap_left   = 0;
    text_item_t  next_item;
    line_hit_t   want;
    ready_mode_t ready_mode  = READY_ALWAYS;
    int          ready_timer = 0;
    logic        ready_next;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // line predictor
    // ---------------------------------------------------------------

    // pattern lengths past the window size clamp to the window size
    function automatic int unsigned active_pat_len();
        return (cfg_pat_len > PAT_LIMIT) ? PAT_LIMIT : cfg_pat_len;
    endfunction

    function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] b);
        if (cfg_fold && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

    // newest byte sits in window_q[0], so pattern byte 0 lines up with the oldest one
    function automatic logic window_has_pattern();
        int unsigned n;
        n = active_pat_len();
        if (n == 0) return 1'b1;
        // only bytes of the open chunk may take part
        if (fill_count < n) return 1'b0;
        for (int j = 0; j < n; j++) begin
            if (lower_ascii(cfg_pattern[j*BYTE_W +: BYTE_W]) != lower_ascii(window_q[n-1-j])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_line_state();
        for (int k = 0; k < PAT_LIMIT; k++) window_q[k] = '0;
        fill_count   = 0;
        hit_in_chunk = 1'b0;
        nul_in_chunk = 1'b0;
        line_count   = '0;
        cfg_pat_len  = PLEN_W'(1);
        cfg_fold     = 1'b0;
        cfg_invert   = 1'b0;
        cfg_pattern  = '0;
    endtask

    // one accepted byte item, pushes a line item when the chunk closes selected
    task automatic predict_line_hit(input logic [BYTE_W-1:0] b, input logic fin);
        for (int k = PAT_LIMIT - 1; k > 0; k--) window_q[k] = window_q[k-1];
        window_q[0] = b;
        fill_count++;
        // a zero byte blanks the rest of the chunk for matching
        if (b == CHAR_NUL) nul_in_chunk = 1'b1;
        if (!nul_in_chunk && window_has_pattern()) hit_in_chunk = 1'b1;
        if (b == CHAR_NEWLINE || fill_count >= CHUNK_LIMIT || fin) begin
            if (line_count != LINE_NUMBER_MAX) line_count++;
            if (hit_in_chunk != cfg_invert) begin
                expected_hits.push_back('{number: line_count, len: LLEN_W'(fill_count)});
            end
            fill_count   = 0;
            hit_in_chunk = 1'b0;
            nul_in_chunk = 1'b0;
            // next byte opens a new file at line 1
            if (fin) line_count = '0;
        end
    endtask

    // ---------------------------------------------------------------
    // byte driver: bursts of random length with random gaps
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            i_text_byte  <= '0;
            i_final_byte <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_line_hit(i_text_byte, i_final_byte);
                bytes_accepted++;
            end
            // payload only moves once the held item is taken
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_item = pending_bytes.pop_front();
                    i_in_valid   <= 1'b1;
                    i_text_byte  <= next_item.text;
                    i_final_byte <= next_item.ends_file;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        // long stretch with no idling
                        burst_left = $urandom_range(64, 200);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected line item: line_number %0d line_length %0d",
                           o_line_number, o_line_length);
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (o_line_number !== want.number) begin
                        $error("line_number: expected %0d, got %0d", want.number, o_line_number);
                        fail_count++;
                    end
                    if (o_line_length !== want.len) begin
                        $error("line_length: expected %0d, got %0d", want.len, o_line_length);
                        fail_count++;
                    end
                end
            end
            // stall pattern changes when its random timer runs out
            if (ready_timer == 0) begin
                ready_mode  = ready_mode_t'($urandom_range(0, 3));
                ready_timer = $urandom_range(16, 96);
            end else begin
                ready_timer--;
            end
            case (ready_mode)
                READY_ALWAYS: ready_next = 1'b1;
                READY_COIN:   ready_next = 1'($urandom_range(0, 1));
                READY_SPARSE: ready_next = ($urandom_range(0, 5) == 0);
                default:      ready_next = ready_timer[2];
            endcase
            i_out_ready <= ready_next;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // register write, mirrored into the shadow copy on the same edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PATTERN_LENGTH: cfg_pat_len = data[PLEN_W-1:0];
            REG_FOLD_CASE:      cfg_fold    = data[0];
            REG_INVERT_SELECT:  cfg_invert  = data[0];
            REG_PATTERN_WORD_A: cfg_pattern[0*CFG_DATA_W +: CFG_DATA_W] = data;
            REG_PATTERN_WORD_B: cfg_pattern[1*CFG_DATA_W +: CFG_DATA_W] = data;
            REG_PATTERN_WORD_C: cfg_pattern[2*CFG_DATA_W +: CFG_DATA_W] = data;
            REG_PATTERN_WORD_D: cfg_pattern[3*CFG_DATA_W +: CFG_DATA_W] = data;
            default: ;
        endcase
    endtask

    // writes every register; unused upper data bits carry junk
    task automatic load_filter(input logic [PLEN_W-1:0] plen, input logic fold, input logic inv,
                               input logic [PAT_W-1:0] pattern);
        logic [CFG_DATA_W-1:0] data;
        data = {$urandom(), $urandom()};
        data[PLEN_W-1:0] = plen;
        write_reg(REG_PATTERN_LENGTH, data);
        data = {$urandom(), $urandom()};
        data[0] = fold;
        write_reg(REG_FOLD_CASE, data);
        data = {$urandom(), $urandom()};
        data[0] = inv;
        write_reg(REG_INVERT_SELECT, data);
        write_reg(REG_PATTERN_WORD_A, pattern[0*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_WORD_B, pattern[1*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_WORD_C, pattern[2*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_WORD_D, pattern[3*CFG_DATA_W +: CFG_DATA_W]);
        if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, {$urandom(), $urandom()});
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin);
        pending_bytes.push_back('{text: b, ends_file: fin});
        bytes_queued++;
    endtask

    task automatic queue_string(input string s, input logic fin_at_end);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], fin_at_end && (i == s.len() - 1));
    endtask

    // letters a/b in both cases dominate so short patterns also hit by chance
    function automatic logic [BYTE_W-1:0] text_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return BYTE_W'((($urandom_range(0, 1)) ? CHAR_LOWER_A : CHAR_UPPER_A)
                           + $urandom_range(0, 1));
        end
        if (r < 65) return BYTE_W'(CHAR_LOWER_A + $urandom_range(0, 25));
        if (r < 75) return BYTE_W'(CHAR_UPPER_A + $urandom_range(0, 25));
        if (r < 93) return BYTE_W'($urandom_range(8'h20, 8'h7E));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // random length with the extremes and the clamped range, random case mix
    task automatic load_random_filter();
        logic [PLEN_W-1:0] plen;
        logic [PAT_W-1:0]  pattern;
        int unsigned       pick;
        int unsigned       n;
        pick = $urandom_range(0, 19);
        if (pick == 0)      plen = '0;
        else if (pick == 1) plen = PLEN_W'(PAT_LIMIT);
        else if (pick == 2) plen = PLEN_W'($urandom_range(PAT_LIMIT + 1, PLEN_TOP));
        else if (pick <= 5) plen = PLEN_W'($urandom_range(9, PAT_LIMIT - 1));
        else                plen = PLEN_W'($urandom_range(1, 8));
        for (int k = 0; k < PAT_BYTES; k++) begin
            pattern[k*BYTE_W +: BYTE_W] = ($urandom_range(0, 4) == 0)
                ? BYTE_W'($urandom_range(8'h20, 8'h7E))
                : BYTE_W'((($urandom_range(0, 1)) ? CHAR_LOWER_A : CHAR_UPPER_A)
                          + $urandom_range(0, 1));
        end
        n = (plen > PAT_LIMIT) ? PAT_LIMIT : plen;
        // newline can match at a line end, a zero byte never matches
        if (n > 0 && $urandom_range(0, 5) == 0) begin
            pattern[$urandom_range(0, n - 1)*BYTE_W +: BYTE_W] =
                ($urandom_range(0, 1)) ? CHAR_NEWLINE : CHAR_NUL;
        end
        load_filter(plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pattern);
    endtask

    // lines of random text, the pattern planted in most lines that can hold it, some with only a prefix
    task automatic queue_random_text(input int target);
        logic [BYTE_W-1:0] line_q[$];
        logic [BYTE_W-1:0] c;
        int                count;
        int                body;
        int                n;
        int                plant_n;
        int                at;
        logic              noise;
        logic              ends;
        count = 0;
        while (count < target) begin
            line_q.delete();
            body  = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            noise = ($urandom_range(0, 6) == 0);
            for (int i = 0; i < body; i++) begin
                line_q.push_back(noise ? BYTE_W'($urandom_range(0, 255)) : text_char());
            end
            n = active_pat_len();
            if (!noise && n > 0 && body >= n && $urandom_range(0, 9) < 6) begin
                plant_n = (n > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : n;
                at      = $urandom_range(0, body - n);
                for (int j = 0; j < plant_n; j++) begin
                    c = cfg_pattern[j*BYTE_W +: BYTE_W];
                    // swap letter case now and then, a hit only with folding on
                    if (((c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                         (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)) && $urandom_range(0, 3) == 0) begin
                        c = c ^ CASE_OFFSET;
                    end
                    line_q[at + j] = c;
                end
            end
            ends = ($urandom_range(0, 11) == 0);
            if (ends) begin
                if (line_q.size() == 0) line_q.push_back(text_char());
            end else begin
                line_q.push_back(CHAR_NEWLINE);
            end
            for (int i = 0; i < line_q.size(); i++) begin
                push_byte(line_q[i], ends && (i == line_q.size() - 1));
            end
            count += line_q.size();
        end
    endtask

    // every queued item taken and every line item in, then the pipeline settles
    task automatic wait_drained(input int extra);
        while (bytes_accepted != bytes_queued || expected_hits.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        clear_line_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain two-byte pattern, exact case
        load_filter(PLEN_W'(2), 1'b0, 1'b0, PAT_AB);
        queue_string("ab\n", 1'b0);
        queue_string("aB\n", 1'b0);
        // pattern split across two lines never hits
        queue_string("a\n", 1'b0);
        queue_string("b\n", 1'b0);
        // zero byte ahead of the pattern hides it
        push_byte(CHAR_NUL, 1'b0);
        queue_string("ab\n", 1'b0);
        // zero byte after the pattern comes too late to matter
        queue_string("ab", 1'b0);
        push_byte(CHAR_NUL, 1'b0);
        push_byte(CHAR_NEWLINE, 1'b0);
        // last byte of the file closes the line with no newline
        push_byte(8'hFF, 1'b0);
        queue_string("ab", 1'b1);
        wait_drained(DRAIN_CYCLES);

        // empty pattern is in every line unless a zero byte leads, inverted
        load_filter('0, 1'b1, 1'b1, '0);
        queue_string("Q\n", 1'b0);
        push_byte(CHAR_NUL, 1'b0);
        push_byte(CHAR_NEWLINE, 1'b0);
        wait_drained(DRAIN_CYCLES);

        // case folding on both sides
        load_filter(PLEN_W'(2), 1'b1, 1'b0, PAT_AB);
        queue_string("AB\n", 1'b0);
        wait_drained(DRAIN_CYCLES);

        // random phases, each with a fresh filter setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_random_filter();
            queue_random_text(PHASE_BYTES);
            wait_drained(DRAIN_CYCLES);
        end

        // over-long line: first chunk is cut at the length limit in the middle of
        // the pattern, so neither chunk holds it and both come out inverted
        load_filter(PLEN_W'(4), 1'b0, 1'b1, PAT_ABCD);
        for (int i = 0; i < CHUNK_LIMIT - 2; i++) push_byte(CHAR_FILL, 1'b0);
        queue_string("abcd\n", 1'b0);

        wait_drained(END_CYCLES);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
